// ===== hw/rtl/rdwr_pkg.sv =====
// Shared types and constants for the random draw without replacement block.
// No dependencies; used by rdwr_ctrl, rdwr_datapath and the top level.
package rdwr_pkg;

  localparam int RND_W     = 32;   // random word width, also divider step count
  localparam int ENT_IO_W  = 32;   // entry width on the ports
  localparam int INDEX_W   = 13;
  localparam int REMAIN_W  = 14;
  localparam int DIV_CNT_W = 5;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(RND_W - 1);

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_DRAW   = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic                operation;
    logic [ENT_IO_W-1:0] entry_in;
    logic [RND_W-1:0]    random_word;
  } in_word_t;

  typedef struct packed {
    logic [ENT_IO_W-1:0] entry_out;
    logic [INDEX_W-1:0]  index_out;
    logic [REMAIN_W-1:0] remaining;
    logic                pool_emptied;
    logic [1:0]          status;
  } out_word_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DECODE,
    CS_DIV,
    CS_READ,
    CS_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic latch;       // capture accepted input word
    logic append;      // write entry, bump count, emit
    logic reject;      // emit error status, no state change
    logic div_start;   // load remainder divider
    logic div_step;    // one restoring division step
    logic read;        // read chosen and last entries
    logic finish;      // move last entry, drop count, emit
  } dp_cmd_t;

  typedef struct packed {
    logic is_draw;
    logic pool_empty;
    logic pool_full;
    logic div_last;
  } dp_status_t;

endpackage

// ===== hw/rtl/rdwr_ctrl.sv =====
// Sequencing state machine for the random draw block.
// Depends on rdwr_pkg; drives rdwr_datapath through dp_cmd_t.
module rdwr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  rdwr_pkg::dp_status_t  dp_stat,
  output rdwr_pkg::dp_cmd_t     dp_cmd,
  output logic                  busy
);

  rdwr_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rdwr_pkg::CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rdwr_pkg::CS_IDLE: begin
        if (start) state_nxt = rdwr_pkg::CS_DECODE;
      end
      rdwr_pkg::CS_DECODE: begin
        if (dp_stat.is_draw && !dp_stat.pool_empty) state_nxt = rdwr_pkg::CS_DIV;
        else state_nxt = rdwr_pkg::CS_IDLE;
      end
      rdwr_pkg::CS_DIV: begin
        if (dp_stat.div_last) state_nxt = rdwr_pkg::CS_READ;
      end
      rdwr_pkg::CS_READ:   state_nxt = rdwr_pkg::CS_FINISH;
      rdwr_pkg::CS_FINISH: state_nxt = rdwr_pkg::CS_IDLE;
      default:             state_nxt = rdwr_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd = '0;
    busy   = 1'b1;
    case (state_r)
      rdwr_pkg::CS_IDLE: begin
        busy         = 1'b0;
        dp_cmd.latch = start;
      end
      rdwr_pkg::CS_DECODE: begin
        dp_cmd.append    = !dp_stat.is_draw && !dp_stat.pool_full;
        dp_cmd.reject    = dp_stat.is_draw ? dp_stat.pool_empty : dp_stat.pool_full;
        dp_cmd.div_start = dp_stat.is_draw && !dp_stat.pool_empty;
      end
      rdwr_pkg::CS_DIV:    dp_cmd.div_step = 1'b1;
      rdwr_pkg::CS_READ:   dp_cmd.read     = 1'b1;
      rdwr_pkg::CS_FINISH: dp_cmd.finish   = 1'b1;
      default:             busy            = 1'b1;
    endcase
  end

endmodule

// ===== hw/rtl/rdwr_datapath.sv =====
// Datapath: entry store, count, bit-serial remainder unit and result register.
// Depends on rdwr_pkg; commanded by rdwr_ctrl.
module rdwr_datapath #(
  parameter int POOL_DEPTH  = 8192,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rdwr_pkg::in_word_t    in_word,
  input  rdwr_pkg::dp_cmd_t     dp_cmd,
  output rdwr_pkg::dp_status_t  dp_stat,
  output logic                  out_valid,
  output rdwr_pkg::out_word_t   out_word
);

  localparam int ADDR_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(POOL_DEPTH);

  logic [ENTRY_WIDTH-1:0] mem [POOL_DEPTH];

  rdwr_pkg::in_word_t            item_r;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [CNT_W-1:0]              rem_r, rem_nxt;
  logic [rdwr_pkg::RND_W-1:0]    dvd_r, dvd_nxt;
  logic [rdwr_pkg::DIV_CNT_W-1:0] step_r, step_nxt;
  logic [ENTRY_WIDTH-1:0]        pick_r, last_r;
  logic                          out_valid_r;
  rdwr_pkg::out_word_t           out_r, out_nxt;

  logic [CNT_W:0]         trial, diff;
  logic [CNT_W-1:0]       count_m1;
  logic [ADDR_W-1:0]      idx, last_addr, wr_addr;
  logic                   wr_en;
  logic [ENTRY_WIDTH-1:0] wr_data, new_entry;
  logic [63:0]            in_ext, pick_ext;
  logic [31:0]            idx_ext, rem_ext;

  assign count_m1  = count_r - CNT_W'(1);
  assign idx       = rem_r[ADDR_W-1:0];
  assign last_addr = count_m1[ADDR_W-1:0];
  assign in_ext    = 64'(item_r.entry_in);
  assign new_entry = in_ext[ENTRY_WIDTH-1:0];
  assign pick_ext  = 64'(pick_r);
  assign idx_ext   = 32'(idx);

  assign dp_stat.is_draw    = (item_r.operation == rdwr_pkg::OP_DRAW);
  assign dp_stat.pool_empty = (count_r == '0);
  assign dp_stat.pool_full  = (count_r == FULL_COUNT);
  assign dp_stat.div_last   = (step_r == rdwr_pkg::DIV_LAST);

  // restoring remainder, one dividend bit per step
  assign trial = {rem_r, dvd_r[rdwr_pkg::RND_W-1]};
  assign diff  = trial - {1'b0, count_r};

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    step_nxt = step_r;
    if (dp_cmd.div_start) begin
      rem_nxt  = '0;
      dvd_nxt  = item_r.random_word;
      step_nxt = '0;
    end else if (dp_cmd.div_step) begin
      rem_nxt  = (trial >= {1'b0, count_r}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      dvd_nxt  = dvd_r << 1;
      step_nxt = step_r + rdwr_pkg::DIV_CNT_W'(1);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (dp_cmd.append) count_nxt = count_r + CNT_W'(1);
    else if (dp_cmd.finish) count_nxt = count_m1;
  end

  assign rem_ext = 32'(count_nxt);

  always_comb begin
    out_nxt           = out_r;
    out_nxt.remaining = rem_ext[rdwr_pkg::REMAIN_W-1:0];
    if (dp_cmd.finish) begin
      out_nxt.entry_out    = pick_ext[rdwr_pkg::ENT_IO_W-1:0];
      out_nxt.index_out    = idx_ext[rdwr_pkg::INDEX_W-1:0];
      out_nxt.pool_emptied = (count_m1 == '0);
      out_nxt.status       = rdwr_pkg::STATUS_OK;
    end else begin
      out_nxt.entry_out    = '0;
      out_nxt.index_out    = '0;
      out_nxt.pool_emptied = 1'b0;
      if (dp_cmd.reject) begin
        out_nxt.status = dp_stat.is_draw ? rdwr_pkg::STATUS_EMPTY : rdwr_pkg::STATUS_FULL;
      end else begin
        out_nxt.status = rdwr_pkg::STATUS_OK;
      end
    end
  end

  // single write port: append at the tail, or last entry into the freed slot
  assign wr_en   = dp_cmd.append || dp_cmd.finish;
  assign wr_addr = dp_cmd.finish ? idx : count_r[ADDR_W-1:0];
  assign wr_data = dp_cmd.finish ? last_r : new_entry;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (dp_cmd.read) begin
      pick_r <= mem[idx];
      last_r <= mem[last_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.latch) item_r <= in_word;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    step_r <= step_nxt;
    if (dp_cmd.append || dp_cmd.reject || dp_cmd.finish) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= dp_cmd.append || dp_cmd.reject || dp_cmd.finish;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("pool count above depth");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held two cycles");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.div_step |-> (rem_r < count_r))
    else $error("partial remainder not below count");

  a_finish_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.finish |-> (count_r != '0) && $past(dp_cmd.read))
    else $error("draw finished without read or on empty pool");

endmodule

// ===== hw/rtl/random_draw_without_replacement.sv =====
// Random draw without replacement: append loads the pool, draw removes entry
// (random_word mod count) and refills its slot with the last entry.
// Order of work: an append or a rejected item is decoded, then its result strobed;
// a draw goes through decode, 32 remainder steps, store read, store write, strobe.
// No new item is taken until the last is finished (busy high). Results cannot stall.
// Reset (rst_n low, synchronous): pool count cleared; store contents undefined.
module random_draw_without_replacement #(
  parameter int POOL_DEPTH  = 8192,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // command side: word taken when start is high and busy is low
  input  logic                 start,
  output logic                 busy,
  input  rdwr_pkg::in_word_t   in_word,
  // result side: one-cycle strobe per item, no backpressure
  output logic                 out_valid,
  output rdwr_pkg::out_word_t  out_word
);

  rdwr_pkg::dp_cmd_t    dp_cmd;
  rdwr_pkg::dp_status_t dp_stat;

  // controller: decode, remainder iteration, read, write-back
  rdwr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .dp_stat (dp_stat),
    .dp_cmd  (dp_cmd),
    .busy    (busy)
  );

  // datapath: store, count, divider, result register
  rdwr_datapath #(
    .POOL_DEPTH  (POOL_DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for random_draw_without_replacement (pool append / random draw).
// Depends on rdwr_pkg for the command and result word types, ops and status codes.
module testbench;

  localparam int POOL_DEPTH   = 8192;
  localparam int ENTRY_WIDTH  = 32;
  localparam int DRAW_LATENCY = 36;        // slowest item: a draw, decode through strobe
  localparam int FILL_LEVEL   = 400;       // depth reached before the full drain
  localparam int RANDOM_ITEMS = 1100;
  localparam int CALM_ITEMS   = 200;       // tail of the random mix runs without gaps
  localparam int DRAIN_GUARD  = 100000;    // cycles allowed for results to come home

  // Worst run: ~1.9k items, each a draw plus the longest gap, 2 time units per cycle,
  // then taken about ten times over.
  localparam longint RUN_LIMIT = 64'd2_000_000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  rdwr_pkg::in_word_t  in_word;
  logic                out_valid;
  rdwr_pkg::out_word_t out_word;

  // Shadow of the block: pool contents and fill level, updated at each accepted word.
  logic [ENTRY_WIDTH-1:0] pool_mem [POOL_DEPTH];
  int unsigned            pool_count;

  rdwr_pkg::out_word_t pending_results [$];   // predicted result words, oldest first
  rdwr_pkg::out_word_t expected_word;
  int                  mismatch_count;
  bit                  idling_on;

  random_draw_without_replacement #(
    .POOL_DEPTH (POOL_DEPTH),
    .ENTRY_WIDTH(ENTRY_WIDTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs (busy stuck high, results never arrive).
  initial begin
    #RUN_LIMIT;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Applies one command word to the shadow pool and returns the result word it causes.
  function automatic rdwr_pkg::out_word_t predict_item(rdwr_pkg::in_word_t w);
    rdwr_pkg::out_word_t r;
    int unsigned         pick;
    r = '0;
    if (w.operation == rdwr_pkg::OP_APPEND) begin
      if (pool_count >= POOL_DEPTH) begin
        r.status = rdwr_pkg::STATUS_FULL;  // full pool: nothing changes
      end else begin
        pool_mem[pool_count] = w.entry_in[ENTRY_WIDTH-1:0];
        pool_count++;
        r.status = rdwr_pkg::STATUS_OK;
      end
      r.remaining = rdwr_pkg::REMAIN_W'(pool_count);
    end else if (pool_count == 0) begin
      r.status = rdwr_pkg::STATUS_EMPTY;   // empty pool: all other fields stay zero
    end else begin
      // pick = random mod count, then the last entry fills the hole
      pick           = w.random_word % pool_count;
      r.entry_out    = rdwr_pkg::ENT_IO_W'(pool_mem[pick]);
      r.index_out    = rdwr_pkg::INDEX_W'(pick);
      pool_mem[pick] = pool_mem[pool_count - 1];
      pool_count--;
      r.remaining    = rdwr_pkg::REMAIN_W'(pool_count);
      r.pool_emptied = (pool_count == 0);
      r.status       = rdwr_pkg::STATUS_OK;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Results cannot be held off: every strobe is consumed at the edge ending its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing pending", out_word));
      end else begin
        expected_word = pending_results.pop_front();
        check_field("entry_out", out_word.entry_out, expected_word.entry_out);
        check_field("index_out", out_word.index_out, expected_word.index_out);
        check_field("remaining", out_word.remaining, expected_word.remaining);
        check_field("pool_emptied", out_word.pool_emptied, expected_word.pool_emptied);
        check_field("status", out_word.status, expected_word.status);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic rdwr_pkg::in_word_t make_word(logic op, logic [31:0] entry,
                                                   logic [31:0] rnd);
    rdwr_pkg::in_word_t w;
    w.operation   = op;
    w.entry_in    = entry;
    w.random_word = rnd;
    return w;
  endfunction

  // Random words lean on the corners now and then: zero, all ones, tiny values.
  function automatic logic [31:0] pick_random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // Drive a word at the falling edge, hold it until an edge with busy low takes it.
  // start stays high on return; whoever comes next decides whether it drops.
  task automatic send_word(rdwr_pkg::in_word_t w);
    @(negedge clk);
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_item(w));
  endtask

  // Idle gap of random length; the command bus carries junk meanwhile, start low.
  task automatic idle_burst();
    int n;
    n = $urandom_range(1, 16);
    repeat (n) begin
      @(negedge clk);
      start   <= 1'b0;
      in_word <= make_word(1'($urandom), $urandom, $urandom);
    end
  endtask

  task automatic maybe_idle(int one_in);
    if (idling_on && $urandom_range(1, one_in) == 1) idle_burst();
  endtask

  // Sender holds off until every predicted word has been seen.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty-pool draws, field extremes, last-entry draw, pool emptied flag.
  task automatic test_corners();
    send_word(make_word(rdwr_pkg::OP_DRAW, 32'h0, 32'h0));                 // draw from empty
    send_word(make_word(rdwr_pkg::OP_DRAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF)); // same, all ones
    maybe_idle(2);
    send_word(make_word(rdwr_pkg::OP_APPEND, 32'h0, 32'hFFFF_FFFF));
    send_word(make_word(rdwr_pkg::OP_APPEND, 32'hFFFF_FFFF, 32'h0));
    send_word(make_word(rdwr_pkg::OP_APPEND, 32'h8000_0001, $urandom));
    send_word(make_word(rdwr_pkg::OP_APPEND, 32'h5A5A_A5A5, $urandom));
    maybe_idle(2);
    send_word(make_word(rdwr_pkg::OP_DRAW, $urandom, 32'hFFFF_FFFF));  // picks the last slot
    send_word(make_word(rdwr_pkg::OP_DRAW, $urandom, 32'h0));          // picks slot zero
    maybe_idle(2);
    send_word(make_word(rdwr_pkg::OP_DRAW, $urandom, 32'h8000_0000));
    send_word(make_word(rdwr_pkg::OP_DRAW, $urandom, 32'h7FFF_FFFF));  // removes final entry
    send_word(make_word(rdwr_pkg::OP_DRAW, $urandom, $urandom));       // empty again
    send_word(make_word(rdwr_pkg::OP_APPEND, 32'hDEAD_0F0F, 32'hFFFF_FFFF));
    send_word(make_word(rdwr_pkg::OP_DRAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF)); // count one, emptied
    wait_drained();
  endtask

  // Fill to a deep level, then shuffle it all out and draw once past empty.
  task automatic test_fill_and_drain();
    while (pool_count < FILL_LEVEL)
      send_word(make_word(rdwr_pkg::OP_APPEND, $urandom, $urandom));
    maybe_idle(2);
    while (pool_count != 0) begin
      maybe_idle(16);
      send_word(make_word(rdwr_pkg::OP_DRAW, $urandom, pick_random_word()));
    end
    send_word(make_word(rdwr_pkg::OP_DRAW, $urandom, $urandom));
    wait_drained();
  endtask

  // Mostly load-then-draw traffic around a moderate fill level, with the odd
  // empty-pool draw as noise and occasional runs that empty the pool outright.
  task automatic test_random_mix();
    int  draws_left;
    bit  do_draw;
    draws_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) wait_drained();
      if (i == RANDOM_ITEMS - CALM_ITEMS) idling_on = 1'b0;
      maybe_idle(4);
      if (draws_left == 0 && pool_count > 0 && $urandom_range(0, 59) == 0)
        draws_left = pool_count + 1;                     // run past empty by one
      if (draws_left > 0) begin
        do_draw = 1'b1;
        draws_left--;
      end else if (pool_count == 0) begin
        do_draw = ($urandom_range(0, 9) == 0);
      end else if (pool_count < 48) begin
        do_draw = ($urandom_range(0, 9) < 4);
      end else begin
        do_draw = ($urandom_range(0, 9) < 6);
      end
      send_word(make_word(do_draw ? rdwr_pkg::OP_DRAW : rdwr_pkg::OP_APPEND, $urandom,
                          pick_random_word()));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    int guard;
    start          = 1'b0;
    in_word        = '0;
    rst_n          = 1'b0;
    pool_count     = 0;
    mismatch_count = 0;
    idling_on      = 1'b1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_corners();
    test_fill_and_drain();
    test_random_mix();

    // Let the last results come home, then a draw's worth of quiet.
    @(negedge clk);
    start <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAW_LATENCY + 5) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", pending_results.size()));

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
